// ===== rtl/rde_pkg.sv =====
// shared types and constants for the radio degrade audio effect
`default_nettype none
package rde_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int AVG_W       = 24;
  localparam int DRAW_W      = 16;
  localparam int GAIN_W      = 12;
  localparam int CLIP_W      = 15;
  localparam int CRACKLE_W   = 15;
  localparam int POP_PROB_W  = 16;
  localparam int POP_AMP_W   = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // shared multiplier: 26 x 18 signed, 44 bit product
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int LFSR_STEPS    = 8;
  localparam logic [63:0] LFSR_POLY = 64'h0000_0000_8020_0003;

  // one-pole average weights in Q0.16, output scale
  localparam logic signed [MUL_B_W-1:0] COEF_KEEP = 18'sd62259;
  localparam logic signed [MUL_B_W-1:0] COEF_NEW  = 18'sd3277;
  localparam logic signed [MUL_B_W-1:0] OUT_SCALE = 18'sd20000;

  localparam int AVG_SHIFT   = 16;
  localparam int OUT_SHIFT   = 23;
  localparam int NOISE_SHIFT = 7;
  localparam int GAIN_SHIFT  = 8;
  localparam int POP_SHIFT   = 8;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_OVERDRIVE_GAIN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LEVEL        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CRACKLE_AMPLITUDE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POP_PROBABILITY   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POP_AMPLITUDE     = 3'd4;

  // register reset values
  localparam logic [GAIN_W-1:0]     RST_OVERDRIVE_GAIN    = 12'd512;
  localparam logic [CLIP_W-1:0]     RST_CLIP_LEVEL        = 15'd26214;
  localparam logic [CRACKLE_W-1:0]  RST_CRACKLE_AMPLITUDE = 15'd655;
  localparam logic [POP_PROB_W-1:0] RST_POP_PROBABILITY   = 16'd66;
  localparam logic [POP_AMP_W-1:0]  RST_POP_AMPLITUDE     = 16'd16384;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_AVG_OLD,
    MUL_AVG_NEW,
    MUL_NOISE,
    MUL_GAIN,
    MUL_POP,
    MUL_SCALE
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_PROD,
    ACC_LOAD_NOISE,
    ACC_ADD_CLIP,
    ACC_ADD_POP
  } acc_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     in_load;
    logic     lfsr_adv;
    logic     avg_load;
    logic     out_load;
  } rde_cmd_t;

  typedef struct packed {
    logic pop_hit;
  } rde_status_t;

endpackage
`default_nettype wire

// ===== rtl/radio_degrade_audio_effect.sv =====
// top level of the radio degrade audio effect
// one item is in work at a time: in_ready is high only while idle, and
// an output stall holds a finished result until the output register frees
// the pace is set by the single shared 26x18 multiplier and the noise lfsr,
// which shifts eight times per advance; one 16 bit draw takes two advances
// reset: synchronous, registers to defaults, average to zero, lfsr to one
`default_nettype none
module radio_degrade_audio_effect #(
  parameter int LFSR_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration write port
  input  wire logic                                 cfg_write,
  input  wire logic [rde_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [rde_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input item
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [rde_pkg::SAMPLE_W-1:0]  sample_in,
  input  wire logic                                 last_in,
  // result item
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [rde_pkg::SAMPLE_W-1:0]       sample_out,
  output logic                                      last_out
);
  import rde_pkg::*;

  // commands from the sequencer, status back from the datapath
  rde_cmd_t    cmd;
  rde_status_t status;

  // sequencer: one state per multiply or accumulate step, pop steps
  // only taken when the second draw falls below the pop probability
  rde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: high-pass average, gain and clip, crackle and pop noise,
  // output scaling with rounding and saturation; the output register
  // lets a new item start while the previous result waits
  rde_datapath #(
    .LFSR_WIDTH (LFSR_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .last_in    (last_in),
    .sample_out (sample_out),
    .last_out   (last_out)
  );

endmodule
`default_nettype wire

// ===== rtl/rde_lfsr.sv =====
// galois lfsr noise source, eight shifts per advance
`default_nettype none
module rde_lfsr #(
  parameter int LFSR_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  output logic [rde_pkg::DRAW_W-1:0]      draw
);
  import rde_pkg::*;

  localparam logic [LFSR_WIDTH-1:0] POLY = LFSR_WIDTH'(LFSR_POLY);
  localparam logic [LFSR_WIDTH-1:0] ONE  = LFSR_WIDTH'(1);

  logic [LFSR_WIDTH-1:0] lfsr;
  logic [LFSR_WIDTH-1:0] lfsr_next;
  logic [LFSR_WIDTH-1:0] work;

  // all-zero state reloads with one before each shift
  always_comb begin
    work = lfsr;
    for (int i = 0; i < LFSR_STEPS; i++) begin
      if (work == '0) begin
        work = ONE;
      end
      if (work[0]) begin
        work = (work >> 1) ^ POLY;
      end else begin
        work = work >> 1;
      end
    end
    if (work == '0) begin
      work = ONE;
    end
    lfsr_next = work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= ONE;
    end else if (adv) begin
      lfsr <= lfsr_next;
    end
  end

  assign draw = lfsr[DRAW_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/rde_datapath.sv =====
// datapath: registers, shared multiplier, accumulator and output register
`default_nettype none
module rde_datapath #(
  parameter int LFSR_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire rde_pkg::rde_cmd_t                    cmd,
  output rde_pkg::rde_status_t                      status,
  input  wire logic                                 cfg_write,
  input  wire logic [rde_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [rde_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic signed [rde_pkg::SAMPLE_W-1:0]  sample_in,
  input  wire logic                                 last_in,
  output logic signed [rde_pkg::SAMPLE_W-1:0]       sample_out,
  output logic                                      last_out
);
  import rde_pkg::*;

  localparam logic signed [PROD_W-1:0] AVG_BIAS   = PROD_W'(32768);
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(4194304);
  localparam logic signed [PROD_W-1:0] SAT_HI     = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO     = -PROD_W'(32768);

  logic [GAIN_W-1:0]     overdrive_gain;
  logic [CLIP_W-1:0]     clip_level;
  logic [CRACKLE_W-1:0]  crackle_amplitude;
  logic [POP_PROB_W-1:0] pop_probability;
  logic [POP_AMP_W-1:0]  pop_amplitude;

  logic signed [SAMPLE_W-1:0] smp;
  logic                       last_q;
  logic signed [AVG_W-1:0]    avg_state;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   acc;

  logic [DRAW_W-1:0]          draw;
  logic signed [DRAW_W-1:0]   draw_s;
  logic signed [AVG_W-1:0]    x_q;
  logic signed [AVG_W:0]      hp;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod_next;
  logic signed [PROD_W-1:0]   avg_sum;
  logic signed [PROD_W-1:0]   g_raw;
  logic signed [PROD_W-1:0]   lim;
  logic signed [PROD_W-1:0]   g_clip;
  logic signed [PROD_W-1:0]   acc_next;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [SAMPLE_W-1:0] y_sat;

  rde_lfsr #(
    .LFSR_WIDTH (LFSR_WIDTH)
  ) u_lfsr (
    .clk  (clk),
    .rst  (rst),
    .adv  (cmd.lfsr_adv),
    .draw (draw)
  );

  // draw minus half scale is the draw with its top bit flipped
  assign draw_s = $signed({~draw[DRAW_W-1], draw[DRAW_W-2:0]});
  assign x_q    = {smp, 8'h00};
  assign hp     = (AVG_W+1)'(x_q) - (AVG_W+1)'(avg_state);
  assign status.pop_hit = draw < pop_probability;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_AVG_OLD: begin
        mul_a = MUL_A_W'(avg_state);
        mul_b = COEF_KEEP;
      end
      MUL_AVG_NEW: begin
        mul_a = MUL_A_W'(smp);
        mul_b = COEF_NEW;
      end
      MUL_NOISE: begin
        mul_a = MUL_A_W'(draw_s);
        mul_b = $signed({3'b000, crackle_amplitude});
      end
      MUL_GAIN: begin
        mul_a = MUL_A_W'(hp);
        mul_b = $signed({6'b00_0000, overdrive_gain});
      end
      MUL_POP: begin
        mul_a = MUL_A_W'(draw_s);
        mul_b = $signed({2'b00, pop_amplitude});
      end
      MUL_SCALE: begin
        mul_a = $signed(acc[MUL_A_W-1:0]);
        mul_b = OUT_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // new average: x*3277 is smp*3277 shifted by eight
  assign avg_sum = acc + (prod <<< 8) + AVG_BIAS;

  // gain then symmetric clip
  assign g_raw = prod >>> GAIN_SHIFT;
  assign lim   = {{(PROD_W-CLIP_W-8){1'b0}}, clip_level, 8'h00};

  always_comb begin
    if (g_raw > lim) begin
      g_clip = lim;
    end else if (g_raw < -lim) begin
      g_clip = -lim;
    end else begin
      g_clip = g_raw;
    end
  end

  always_comb begin
    unique case (cmd.acc_op)
      ACC_LOAD_PROD:  acc_next = prod;
      ACC_LOAD_NOISE: acc_next = prod >>> NOISE_SHIFT;
      ACC_ADD_CLIP:   acc_next = acc + g_clip;
      ACC_ADD_POP:    acc_next = acc + (prod >>> POP_SHIFT);
      default:        acc_next = acc;
    endcase
  end

  // round, scale to output counts and saturate
  assign rnd = (prod + ROUND_BIAS) >>> OUT_SHIFT;

  always_comb begin
    if (rnd > SAT_HI) begin
      y_sat = SAMPLE_W'(SAT_HI);
    end else if (rnd < SAT_LO) begin
      y_sat = SAMPLE_W'(SAT_LO);
    end else begin
      y_sat = rnd[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overdrive_gain    <= RST_OVERDRIVE_GAIN;
      clip_level        <= RST_CLIP_LEVEL;
      crackle_amplitude <= RST_CRACKLE_AMPLITUDE;
      pop_probability   <= RST_POP_PROBABILITY;
      pop_amplitude     <= RST_POP_AMPLITUDE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OVERDRIVE_GAIN:    overdrive_gain    <= cfg_data[GAIN_W-1:0];
        REG_CLIP_LEVEL:        clip_level        <= cfg_data[CLIP_W-1:0];
        REG_CRACKLE_AMPLITUDE: crackle_amplitude <= cfg_data[CRACKLE_W-1:0];
        REG_POP_PROBABILITY:   pop_probability   <= cfg_data[POP_PROB_W-1:0];
        REG_POP_AMPLITUDE:     pop_amplitude     <= cfg_data[POP_AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // running average restarts after the last item of a buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_state <= '0;
    end else if (cmd.avg_load) begin
      avg_state <= avg_sum[AVG_SHIFT +: AVG_W];
    end else if (cmd.out_load && last_q) begin
      avg_state <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      smp    <= sample_in;
      last_q <= last_in;
    end
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= prod_next;
    end
    acc <= acc_next;
    if (cmd.out_load) begin
      sample_out <= y_sat;
      last_out   <= last_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rde_ctrl.sv =====
// controller: sequences the datapath and owns both handshakes
`default_nettype none
module rde_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire rde_pkg::rde_status_t status,
  output rde_pkg::rde_cmd_t         cmd
);
  import rde_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_AVG0  = 11'b000_0000_0010,
    ST_AVG1  = 11'b000_0000_0100,
    ST_HP    = 11'b000_0000_1000,
    ST_GAIN  = 11'b000_0001_0000,
    ST_CLIP  = 11'b000_0010_0000,
    ST_POP0  = 11'b000_0100_0000,
    ST_POP1  = 11'b000_1000_0000,
    ST_POP2  = 11'b001_0000_0000,
    ST_SCALE = 11'b010_0000_0000,
    ST_ROUND = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd.mul_sel  = MUL_NONE;
    cmd.acc_op   = ACC_HOLD;
    cmd.in_load  = 1'b0;
    cmd.lfsr_adv = 1'b0;
    cmd.avg_load = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = ST_AVG0;
        end
      end
      ST_AVG0: begin
        cmd.mul_sel  = MUL_AVG_OLD;
        cmd.lfsr_adv = 1'b1;
        state_next   = ST_AVG1;
      end
      ST_AVG1: begin
        cmd.mul_sel  = MUL_AVG_NEW;
        cmd.acc_op   = ACC_LOAD_PROD;
        cmd.lfsr_adv = 1'b1;
        state_next   = ST_HP;
      end
      ST_HP: begin
        cmd.mul_sel  = MUL_NOISE;
        cmd.avg_load = 1'b1;
        cmd.lfsr_adv = 1'b1;
        state_next   = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.mul_sel  = MUL_GAIN;
        cmd.acc_op   = ACC_LOAD_NOISE;
        cmd.lfsr_adv = 1'b1;
        state_next   = ST_CLIP;
      end
      ST_CLIP: begin
        cmd.acc_op = ACC_ADD_CLIP;
        if (status.pop_hit) begin
          cmd.lfsr_adv = 1'b1;
          state_next   = ST_POP0;
        end else begin
          state_next = ST_SCALE;
        end
      end
      ST_POP0: begin
        cmd.lfsr_adv = 1'b1;
        state_next   = ST_POP1;
      end
      ST_POP1: begin
        cmd.mul_sel = MUL_POP;
        state_next  = ST_POP2;
      end
      ST_POP2: begin
        cmd.acc_op = ACC_ADD_POP;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.mul_sel = MUL_SCALE;
        state_next  = ST_ROUND;
      end
      ST_ROUND: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // a result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken item");

  // accept and result load never coincide
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !cmd.out_load)
    else $error("accept and result load in one cycle");

  // no result load during the AVG0 to SCALE steps that follow an accept
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !cmd.out_load ##1 !cmd.out_load ##1 !cmd.out_load
      ##1 !cmd.out_load ##1 !cmd.out_load ##1 !cmd.out_load)
    else $error("result loaded too early");

  // the noise source only moves while an item is in work
  a_lfsr_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.lfsr_adv |-> !in_ready)
    else $error("noise source advanced while idle");
`endif

endmodule
`default_nettype wire

// ===== test/radio_degrade_audio_effect_test.sv =====
// self-checking testbench for the radio degrade audio effect: random settings, items and stalls
`timescale 1ns / 1ps
module radio_degrade_audio_effect_test;

  // one sample item, used for both directions
  typedef struct {
    logic signed [rde_pkg::SAMPLE_W-1:0] sample;
    logic                                last;
  } sample_item_t;

  // high-pass weights in q0.16, output scale and noise lfsr taps
  localparam longint AVG_KEEP_Q16 = 62259;
  localparam longint AVG_NEW_Q16  = 3277;
  localparam longint OUT_GAIN     = 20000;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  localparam int NUM_REGS        = 5;
  localparam int MAX_REPORTS     = 10;
  localparam int SETTLE_CYCLES   = 24;    // longer than the worst-case latency, which is the pop path
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int HOLD_AFTER      = 550;   // items accepted before the long output hold
  localparam int HOLD_CYCLES     = 400;
  localparam int TIMEOUT_NS      = 4_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                 cfg_write = 1'b0;
  logic [rde_pkg::CFG_INDEX_W-1:0]      cfg_index = '0;
  logic [rde_pkg::CFG_DATA_W-1:0]       cfg_data  = '0;
  logic                                 in_valid  = 1'b0;
  logic                                 in_ready;
  logic signed [rde_pkg::SAMPLE_W-1:0]  sample_in = '0;
  logic                                 last_in   = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [rde_pkg::SAMPLE_W-1:0]  sample_out;
  logic                                 last_out;

  radio_degrade_audio_effect u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .last_in    (last_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .last_out   (last_out)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the settings as the block should hold them
  logic [rde_pkg::GAIN_W-1:0]     gain_cfg;
  logic [rde_pkg::CLIP_W-1:0]     clip_cfg;
  logic [rde_pkg::CRACKLE_W-1:0]  crackle_cfg;
  logic [rde_pkg::POP_PROB_W-1:0] pop_prob_cfg;
  logic [rde_pkg::POP_AMP_W-1:0]  pop_amp_cfg;

  // shadow of the running average (q1.23) and the noise generator
  logic signed [rde_pkg::AVG_W-1:0] avg_state;
  logic [31:0]                      noise_state;

  sample_item_t pending_items[$];   // items waiting for the driver
  sample_item_t degraded_q[$];      // degraded samples still owed by the block

  int  accepted_count = 0;
  int  err_count      = 0;
  int  tx_gap         = 0;
  int  rx_stall       = 0;
  bit  tx_idle        = 1'b1;
  bit  rx_idle        = 1'b1;
  logic hold_off      = 1'b0;
  sample_item_t tx_item;
  sample_item_t want;

  // one 16 bit draw: sixteen galois steps, reloading a zero state with one
  function automatic logic [15:0] noise_draw();
    logic [31:0] s;
    s = noise_state;
    for (int i = 0; i < 16; i++) begin
      if (s == '0) s = 32'd1;
      if (s[0]) s = (s >> 1) ^ LFSR_TAPS;
      else s = s >> 1;
    end
    if (s == '0) s = 32'd1;
    noise_state = s;
    return s[15:0];
  endfunction

  // full chain for one accepted item; advances the average and the lfsr
  function automatic sample_item_t degrade_sample(logic signed [15:0] smp, logic last);
    longint x, avg, hp, g, lim, s, y;
    logic [15:0] d1, d2, d3;
    sample_item_t r;
    x   = longint'(smp) * 256;
    avg = (longint'(avg_state) * AVG_KEEP_Q16 + x * AVG_NEW_Q16 + 32768) >>> 16;
    hp  = x - avg;
    // overdrive then symmetric clip
    g   = (hp * longint'(gain_cfg)) >>> 8;
    lim = longint'(clip_cfg) * 256;
    if (g > lim) g = lim;
    if (g < -lim) g = -lim;
    // crackle, then the pop test and possibly a pop
    d1 = noise_draw();
    s  = g + (((longint'(d1) - 32768) * longint'(crackle_cfg)) >>> 7);
    d2 = noise_draw();
    if (d2 < pop_prob_cfg) begin
      d3 = noise_draw();
      s += ((longint'(d3) - 32768) * longint'(pop_amp_cfg)) >>> 8;
    end
    // scale to output counts with rounding, then saturate
    y = (s * OUT_GAIN + (longint'(1) << 22)) >>> 23;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    avg_state = last ? '0 : avg[rde_pkg::AVG_W-1:0];
    r.sample = y[15:0];
    r.last   = last;
    return r;
  endfunction

  // writes to unknown indexes are dropped by the block
  function automatic void apply_setting(logic [rde_pkg::CFG_INDEX_W-1:0] idx,
                                        logic [rde_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      rde_pkg::REG_OVERDRIVE_GAIN:    gain_cfg     = data[rde_pkg::GAIN_W-1:0];
      rde_pkg::REG_CLIP_LEVEL:        clip_cfg     = data[rde_pkg::CLIP_W-1:0];
      rde_pkg::REG_CRACKLE_AMPLITUDE: crackle_cfg  = data[rde_pkg::CRACKLE_W-1:0];
      rde_pkg::REG_POP_PROBABILITY:   pop_prob_cfg = data[rde_pkg::POP_PROB_W-1:0];
      rde_pkg::REG_POP_AMPLITUDE:     pop_amp_cfg  = data[rde_pkg::POP_AMP_W-1:0];
      default: ;
    endcase
  endfunction

  // random register data: masked zero, masked all-ones, small, or anything
  function automatic logic [15:0] pick_setting(int width);
    logic [15:0] mask, r;
    mask = 16'((32'd1 << width) - 1);
    r    = 16'($urandom);
    case ($urandom_range(0, 4))
      0: return r & ~mask;
      1: return r | mask;
      2: return r & (mask >> 4);
      default: return r;
    endcase
  endfunction

  // sample content: full scale, small signals, or anything
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'(int'($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // called at a rising edge; leaves the write strobe high
  task automatic write_reg(input logic [rde_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rde_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_setting(idx, data);
  endtask

  // every register plus one write to an unused index, back to back
  task automatic program_settings(input logic [15:0] gain, clip, crackle, prob, amp);
    write_reg(rde_pkg::CFG_INDEX_W'($urandom_range(NUM_REGS,
              (1 << rde_pkg::CFG_INDEX_W) - 1)), 16'($urandom));
    write_reg(rde_pkg::REG_OVERDRIVE_GAIN, gain);
    write_reg(rde_pkg::REG_CLIP_LEVEL, clip);
    write_reg(rde_pkg::REG_CRACKLE_AMPLITUDE, crackle);
    write_reg(rde_pkg::REG_POP_PROBABILITY, prob);
    write_reg(rde_pkg::REG_POP_AMPLITUDE, amp);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_item(input logic signed [15:0] smp, input logic last);
    pending_items.push_back('{smp, last});
  endtask

  // mostly whole buffers closed by a last item, now and then a stray item
  task automatic queue_buffers(input int n);
    int made, len;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_item(pick_sample(), 1'($urandom));
        made++;
      end else begin
        len = $urandom_range(1, 48);
        for (int k = 0; k < len; k++) queue_item(pick_sample(), k == len - 1);
        made += len;
      end
    end
  endtask

  // wait until the block has nothing in hand, then let it settle
  task automatic drain();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || degraded_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver: offers queued items, predicts each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        degraded_q.push_back(degrade_sample(sample_in, last_in));
        accepted_count++;
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          tx_item = pending_items.pop_front();
          in_valid  <= 1'b1;
          sample_in <= tx_item.sample;
          last_in   <= tx_item.last;
          tx_gap = tx_idle ? $urandom_range(0, 15) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction, stalls at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (degraded_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: unexpected item: sample %0d last %0b",
                     $time, sample_out, last_out);
        end else begin
          want = degraded_q.pop_front();
          if (sample_out !== want.sample || last_out !== want.last) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: mismatch: sample %0d last %0b, expected sample %0d last %0b",
                       $time, sample_out, last_out, want.sample, want.last);
          end
        end
        rx_stall = rx_idle ? $urandom_range(0, 15) : 0;
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // long output hold while the sender keeps offering, so the block backs up
  initial begin
    wait (accepted_count >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // safety net against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // stimulus sequence
  initial begin
    gain_cfg     = rde_pkg::RST_OVERDRIVE_GAIN;
    clip_cfg     = rde_pkg::RST_CLIP_LEVEL;
    crackle_cfg  = rde_pkg::RST_CRACKLE_AMPLITUDE;
    pop_prob_cfg = rde_pkg::RST_POP_PROBABILITY;
    pop_amp_cfg  = rde_pkg::RST_POP_AMPLITUDE;
    avg_state    = '0;
    noise_state  = 32'd1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default settings: full-scale steps, and buffer ends clearing the average
    @(negedge clk);
    queue_item(16'sh7FFF, 1'b0);
    queue_item(16'sh7FFF, 1'b0);
    queue_item(16'sh8000, 1'b0);
    queue_item(16'sh8000, 1'b0);
    queue_item(16'sh0000, 1'b0);
    queue_item(16'sh0001, 1'b0);
    queue_item(16'shFFFF, 1'b1);
    queue_item(16'sh7FFF, 1'b1);      // single item buffer
    queue_item(16'sh8000, 1'b0);
    queue_item(16'sh4000, 1'b0);
    queue_item(16'shC000, 1'b1);

    // zero gain: only crackle gets through, pops never fire
    drain();
    program_settings(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    @(negedge clk);
    queue_item(16'sh7FFF, 1'b0);
    queue_item(16'sh8000, 1'b0);
    queue_item(16'sh0000, 1'b1);

    // zero clip and zero crackle: pops on nearly every item at full size
    drain();
    program_settings(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    @(negedge clk);
    queue_item(16'sh7FFF, 1'b0);
    queue_item(16'sh8000, 1'b0);
    queue_item(16'sd12345, 1'b1);

    // everything at the top, driving the output into saturation both ways
    drain();
    program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    @(negedge clk);
    queue_item(16'sh7FFF, 1'b0);
    queue_item(16'sh8000, 1'b0);
    queue_item(16'sh7FFF, 1'b0);
    queue_item(16'sh8000, 1'b0);
    queue_item(16'sh0000, 1'b0);
    queue_item(16'shFFFF, 1'b1);

    // random settings per phase, idling patterns varying, first phase without gaps
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      program_settings(pick_setting(rde_pkg::GAIN_W), pick_setting(rde_pkg::CLIP_W),
                       pick_setting(rde_pkg::CRACKLE_W), pick_setting(rde_pkg::POP_PROB_W),
                       pick_setting(rde_pkg::POP_AMP_W));
      @(negedge clk);
      tx_idle = (ph % 2) != 0;
      rx_idle = (ph % 3) != 0;
      queue_buffers(ITEMS_PER_PHASE);
    end

    drain();
    if (err_count == 0 && degraded_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rde_pkg.sv
rtl/rde_lfsr.sv
rtl/rde_datapath.sv
rtl/rde_ctrl.sv
rtl/radio_degrade_audio_effect.sv
test/radio_degrade_audio_effect_test.sv
